// ----- rtl/gwm_pkg.sv -----
// ----------------------------------------------------------------------------
// gwm_pkg
// Shared constants for the glob wildcard matcher: register map, pattern
// storage sizes and the pattern syntax characters.
// ----------------------------------------------------------------------------
package gwm_pkg;

   localparam int WORD_W    = 64;
   localparam int NWORDS    = 4;
   localparam int PAT_BYTES = NWORDS * WORD_W / 8;
   localparam int BYTE_IW   = $clog2(PAT_BYTES);
   localparam int LEN_W     = 6;
   localparam int CSR_IDX_W = 3;

   localparam logic [CSR_IDX_W-1:0] CSR_PATTERN_WORD_0 = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PATTERN_WORD_1 = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_PATTERN_WORD_2 = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_PATTERN_WORD_3 = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_PATTERN_LENGTH = 3'd4;

   localparam logic [7:0] CH_STAR  = 8'h2A;
   localparam logic [7:0] CH_QUEST = 8'h3F;
   localparam logic [7:0] CH_OPEN  = 8'h5B;
   localparam logic [7:0] CH_BANG  = 8'h21;
   localparam logic [7:0] CH_DASH  = 8'h2D;
   localparam logic [7:0] CH_CLOSE = 8'h5D;

   typedef logic [7:0] byte_type;

endpackage

// ----- rtl/gwm_decoder.sv -----
// ----------------------------------------------------------------------------
// gwm_decoder
// Walks the pattern one element per cycle and builds the token tables: star
// and negate flags per token, and a byte interval with its owning token per
// pattern position.
// ----------------------------------------------------------------------------
module gwm_decoder #(
   parameter int PLEN = 32
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   input  gwm_pkg::byte_type                    pat_b [gwm_pkg::PAT_BYTES],
   input  logic [gwm_pkg::LEN_W-1:0]            pat_len,
   output logic                                 busy,
   output logic [PLEN-1:0]                      elem_valid,
   output gwm_pkg::byte_type                    elem_lo [PLEN],
   output gwm_pkg::byte_type                    elem_hi [PLEN],
   output logic [$clog2(PLEN)-1:0]              elem_tok [PLEN],
   output logic [PLEN-1:0]                      tok_star,
   output logic [PLEN-1:0]                      tok_neg,
   output logic [$clog2(PLEN+1)-1:0]            tok_count,
   output logic [PLEN:0]                        init_pos
);
   import gwm_pkg::*;

   localparam int PW = $clog2(PLEN + 1);
   localparam int IW = $clog2(PLEN);

   typedef enum logic [2:0] {
      ST_START, ST_SCAN, ST_BANG, ST_SET, ST_FINISH, ST_IDLE
   } state_type;

   state_type         state_ff;
   logic [PW-1:0]     p_ff;
   logic [PW-1:0]     t_ff;
   logic              last_star_ff;
   logic              have_prev_ff;
   byte_type          prev_ff;
   logic [PLEN-1:0]   elem_valid_ff;
   byte_type          elem_lo_ff [PLEN];
   byte_type          elem_hi_ff [PLEN];
   logic [IW-1:0]     elem_tok_ff [PLEN];
   logic [PLEN-1:0]   tok_star_ff;
   logic [PLEN-1:0]   tok_neg_ff;
   logic [PW-1:0]     tok_count_ff;
   logic [PLEN:0]     init_pos_ff;

   logic [PW-1:0]     len_eff;
   logic [PW-1:0]     p_next1;
   byte_type          byte_p;
   byte_type          byte_p1;
   logic              in_pat;
   logic              in_pat1;
   logic [PLEN:0]     star_ext;

   assign len_eff  = (pat_len > LEN_W'(PLEN)) ? PW'(PLEN) : PW'(pat_len);
   assign p_next1  = PW'(p_ff + 1'b1);
   assign byte_p   = pat_b[BYTE_IW'(p_ff)];
   assign byte_p1  = pat_b[BYTE_IW'(p_next1)];
   assign in_pat   = p_ff < len_eff;
   assign in_pat1  = p_next1 < len_eff;
   assign star_ext = {1'b0, tok_star_ff};

   always_ff @(posedge clock) begin
      case (state_ff)
         ST_START: begin
            p_ff          <= '0;
            t_ff          <= '0;
            last_star_ff  <= 1'b0;
            elem_valid_ff <= '0;
            tok_star_ff   <= '0;
            tok_neg_ff    <= '0;
            state_ff      <= ST_SCAN;
         end
         ST_SCAN: begin
            if (in_pat) begin
               if (byte_p == CH_STAR) begin
                  if (!last_star_ff) begin
                     tok_star_ff[IW'(t_ff)] <= 1'b1;
                     t_ff                   <= PW'(t_ff + 1'b1);
                  end
                  last_star_ff <= 1'b1;
                  p_ff         <= p_next1;
               end else if (byte_p == CH_OPEN) begin
                  last_star_ff <= 1'b0;
                  have_prev_ff <= 1'b0;
                  p_ff         <= p_next1;
                  state_ff     <= ST_BANG;
               end else begin
                  last_star_ff              <= 1'b0;
                  elem_valid_ff[IW'(p_ff)] <= 1'b1;
                  elem_tok_ff[IW'(p_ff)]   <= IW'(t_ff);
                  elem_lo_ff[IW'(p_ff)]    <= (byte_p == CH_QUEST) ? 8'h00 : byte_p;
                  elem_hi_ff[IW'(p_ff)]    <= (byte_p == CH_QUEST) ? 8'hFF : byte_p;
                  t_ff                      <= PW'(t_ff + 1'b1);
                  p_ff                      <= p_next1;
               end
            end else begin
               tok_count_ff <= t_ff;
               state_ff     <= ST_FINISH;
            end
         end
         ST_BANG: begin
            if (in_pat && byte_p == CH_BANG) begin
               tok_neg_ff[IW'(t_ff)] <= 1'b1;
               p_ff                  <= p_next1;
            end
            state_ff <= ST_SET;
         end
         ST_SET: begin
            if (in_pat && byte_p != CH_CLOSE) begin
               elem_valid_ff[IW'(p_ff)] <= 1'b1;
               elem_tok_ff[IW'(p_ff)]   <= IW'(t_ff);
               have_prev_ff              <= 1'b1;
               if (byte_p == CH_DASH && have_prev_ff && in_pat1 && byte_p1 != CH_CLOSE) begin
                  elem_lo_ff[IW'(p_ff)] <= prev_ff;
                  elem_hi_ff[IW'(p_ff)] <= byte_p1;
                  prev_ff               <= byte_p1;
                  p_ff                  <= PW'(p_ff + 2'd2);
               end else begin
                  elem_lo_ff[IW'(p_ff)] <= byte_p;
                  elem_hi_ff[IW'(p_ff)] <= byte_p;
                  prev_ff               <= byte_p;
                  p_ff                  <= p_next1;
               end
            end else begin
               if (in_pat) begin
                  p_ff <= p_next1;
               end
               t_ff     <= PW'(t_ff + 1'b1);
               state_ff <= ST_SCAN;
            end
         end
         ST_FINISH: begin
            // closure of the start position over leading stars
            init_pos_ff <= (PLEN+1)'(1) |
                           ((((PLEN+1)'(1) & star_ext) + star_ext) ^ star_ext);
            state_ff    <= ST_IDLE;
         end
         ST_IDLE: begin
         end
         default: begin
            state_ff <= ST_START;
         end
      endcase
      if (reset || start) begin
         state_ff <= ST_START;
      end
   end

   assign busy       = state_ff != ST_IDLE;
   assign elem_valid = elem_valid_ff;
   assign elem_lo    = elem_lo_ff;
   assign elem_hi    = elem_hi_ff;
   assign elem_tok   = elem_tok_ff;
   assign tok_star   = tok_star_ff;
   assign tok_neg    = tok_neg_ff;
   assign tok_count  = tok_count_ff;
   assign init_pos   = init_pos_ff;

   a_count_bounded: assert property (@(posedge clock) disable iff (reset)
      !busy |-> tok_count_ff <= PW'(PLEN))
      else $error("token count beyond pattern size");

   a_start_busy: assert property (@(posedge clock) disable iff (reset)
      start |=> busy)
      else $error("decoder idle after restart");

   a_finish_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FINISH && !start) |=> !busy)
      else $error("decoder did not settle");

endmodule

// ----- rtl/gwm_nfa.sv -----
// ----------------------------------------------------------------------------
// gwm_nfa
// Position set of the pattern automaton: matches one name byte against the
// token tables and advances the registered, closed position set on each step.
// ----------------------------------------------------------------------------
module gwm_nfa #(
   parameter int PLEN = 32
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 step,
   input  gwm_pkg::byte_type                    name_byte,
   input  logic                                 is_last,
   input  logic                                 is_empty,
   input  logic [PLEN-1:0]                      elem_valid,
   input  gwm_pkg::byte_type                    elem_lo [PLEN],
   input  gwm_pkg::byte_type                    elem_hi [PLEN],
   input  logic [$clog2(PLEN)-1:0]              elem_tok [PLEN],
   input  logic [PLEN-1:0]                      tok_star,
   input  logic [PLEN-1:0]                      tok_neg,
   input  logic [$clog2(PLEN+1)-1:0]            tok_count,
   input  logic [PLEN:0]                        init_pos,
   output logic                                 matched
);
   import gwm_pkg::*;

   localparam int IW = $clog2(PLEN);

   logic [PLEN:0]   active_ff;
   logic            fresh_ff;
   logic [PLEN:0]   active_in;

   logic [PLEN-1:0] elem_hit;
   logic [PLEN-1:0] tok_hit;
   logic [PLEN:0]   cur;
   logic [PLEN:0]   nxt;
   logic [PLEN:0]   star_ext;
   logic [PLEN:0]   closed;

   assign cur      = fresh_ff ? init_pos : active_ff;
   assign star_ext = {1'b0, tok_star};

   always_comb begin
      for (int p = 0; p < PLEN; p++) begin
         elem_hit[p] = elem_valid[p] && name_byte >= elem_lo[p] && name_byte <= elem_hi[p];
      end
   end

   always_comb begin
      logic acc;
      for (int t = 0; t < PLEN; t++) begin
         acc = 1'b0;
         for (int p = 0; p < PLEN; p++) begin
            acc = acc | (elem_hit[p] && elem_tok[p] == IW'(t));
         end
         tok_hit[t] = acc ^ tok_neg[t];
      end
   end

   always_comb begin
      nxt = '0;
      for (int i = 0; i < PLEN; i++) begin
         if (cur[i] && tok_star[i]) begin
            nxt[i] = 1'b1;
         end else if (cur[i] && tok_hit[i]) begin
            nxt[i+1] = 1'b1;
         end
      end
   end

   // runs of stars pass an active position on through carry propagation
   assign closed    = nxt | (((nxt & star_ext) + star_ext) ^ star_ext);
   assign active_in = is_empty ? active_ff : closed;
   assign matched   = is_empty ? cur[tok_count] : closed[tok_count];

   always_ff @(posedge clock) begin
      if (reset) begin
         fresh_ff <= 1'b1;
      end else if (step) begin
         if (is_last) begin
            fresh_ff <= 1'b1;
         end else if (!is_empty) begin
            fresh_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (step && !is_empty) begin
         active_ff <= active_in;
      end
   end

   a_last_fresh: assert property (@(posedge clock) disable iff (reset)
      (step && is_last) |=> fresh_ff)
      else $error("position set not restarted after end of name");

   a_byte_leaves_start: assert property (@(posedge clock) disable iff (reset)
      (step && !is_last && !is_empty) |=> !fresh_ff)
      else $error("consumed byte did not update the position set");

   a_empty_holds: assert property (@(posedge clock) disable iff (reset)
      (step && !is_last && is_empty) |=> $stable(fresh_ff))
      else $error("empty word changed the position set");

endmodule

// ----- rtl/glob_wildcard_matcher.sv -----
// ----------------------------------------------------------------------------
// glob_wildcard_matcher
// Matches a stream of name bytes against a glob pattern ('*', '?', sets and
// ranges) held in configuration registers; answers on the last byte.
//
//   channel   dir   handshake             payload
//   req       in    req_valid/req_ready   req_name_byte, req_is_last, req_is_empty
//   rsp       out   rsp_valid/rsp_ready   rsp_matched
//   csr       in    csr_we                csr_index, csr_wdata
//
// one word per cycle while the decoder is idle and no ending word waits on a
// stalled result: input register, then the position update into the result
// register; every register write re-decodes the pattern, one pattern element
// per cycle, with req_ready low until that decode ends after the last write;
// the same walk runs after reset
// a stalled result holds only words that end a name; other words keep flowing
// ----------------------------------------------------------------------------
module glob_wildcard_matcher #(
   parameter int PATTERN_MAX = 32
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic [7:0]                         req_name_byte,
   input  logic                               req_is_last,
   input  logic                               req_is_empty,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic                               rsp_matched,
   input  logic                               csr_we,
   input  logic [gwm_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [gwm_pkg::WORD_W-1:0]         csr_wdata
);
   import gwm_pkg::*;

   localparam int PLEN = (PATTERN_MAX < PAT_BYTES) ? PATTERN_MAX : PAT_BYTES;

   logic [WORD_W-1:0]        pat_word_ff [NWORDS];
   logic [LEN_W-1:0]         pat_len_ff;
   byte_type                 pat_b [PAT_BYTES];

   logic                     s1_valid_ff;
   byte_type                 s1_byte_ff;
   logic                     s1_last_ff;
   logic                     s1_empty_ff;
   logic                     rsp_valid_ff;
   logic                     rsp_matched_ff;

   logic                     dec_busy;
   logic [PLEN-1:0]          elem_valid;
   byte_type                 elem_lo [PLEN];
   byte_type                 elem_hi [PLEN];
   logic [$clog2(PLEN)-1:0]  elem_tok [PLEN];
   logic [PLEN-1:0]          tok_star;
   logic [PLEN-1:0]          tok_neg;
   logic [$clog2(PLEN+1)-1:0] tok_count;
   logic [PLEN:0]            init_pos;
   logic                     step_matched;
   logic                     s1_advance;
   logic                     req_fire;

   always_comb begin
      for (int k = 0; k < PAT_BYTES; k++) begin
         pat_b[k] = pat_word_ff[k / 8][(k % 8) * 8 +: 8];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int w = 0; w < NWORDS; w++) begin
            pat_word_ff[w] <= '0;
         end
         pat_len_ff <= '0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_PATTERN_WORD_0: pat_word_ff[0] <= csr_wdata;
            CSR_PATTERN_WORD_1: pat_word_ff[1] <= csr_wdata;
            CSR_PATTERN_WORD_2: pat_word_ff[2] <= csr_wdata;
            CSR_PATTERN_WORD_3: pat_word_ff[3] <= csr_wdata;
            CSR_PATTERN_LENGTH: pat_len_ff     <= csr_wdata[LEN_W-1:0];
            default: begin
            end
         endcase
      end
   end

   gwm_decoder #(.PLEN(PLEN)) u_decoder (
      .clock      (clock),
      .reset      (reset),
      .start      (csr_we),
      .pat_b      (pat_b),
      .pat_len    (pat_len_ff),
      .busy       (dec_busy),
      .elem_valid (elem_valid),
      .elem_lo    (elem_lo),
      .elem_hi    (elem_hi),
      .elem_tok   (elem_tok),
      .tok_star   (tok_star),
      .tok_neg    (tok_neg),
      .tok_count  (tok_count),
      .init_pos   (init_pos)
   );

   assign s1_advance = s1_valid_ff && (!s1_last_ff || !rsp_valid_ff || rsp_ready);
   assign req_ready  = !dec_busy && (!s1_valid_ff || s1_advance);
   assign req_fire   = req_valid && req_ready;

   gwm_nfa #(.PLEN(PLEN)) u_nfa (
      .clock      (clock),
      .reset      (reset),
      .step       (s1_advance),
      .name_byte  (s1_byte_ff),
      .is_last    (s1_last_ff),
      .is_empty   (s1_empty_ff),
      .elem_valid (elem_valid),
      .elem_lo    (elem_lo),
      .elem_hi    (elem_hi),
      .elem_tok   (elem_tok),
      .tok_star   (tok_star),
      .tok_neg    (tok_neg),
      .tok_count  (tok_count),
      .init_pos   (init_pos),
      .matched    (step_matched)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_fire) begin
         s1_valid_ff <= 1'b1;
      end else if (s1_advance) begin
         s1_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_byte_ff  <= req_name_byte;
         s1_last_ff  <= req_is_last;
         s1_empty_ff <= req_is_empty;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (s1_advance && s1_last_ff) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_advance && s1_last_ff) begin
         rsp_matched_ff <= step_matched;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_matched = rsp_matched_ff;

   a_busy_blocks: assert property (@(posedge clock) disable iff (reset)
      dec_busy |-> !req_ready)
      else $error("word accepted during pattern decode");

   a_rsp_from_last: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(s1_advance && s1_last_ff))
      else $error("result without an ending word");

   a_csr_decodes: assert property (@(posedge clock) disable iff (reset)
      csr_we |=> dec_busy)
      else $error("register write did not restart decode");

endmodule
